>>> rtl/core/first_fit_extent_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define FFEA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define FFEA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ffea_pkg.sv
package ffea_pkg;

  // Width of addresses and lengths.
  localparam int unsigned WORD_W = 32;

  // Request codes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // One free extent as stored in the table.
  typedef struct packed {
    word_t base;
    word_t len;
  } extent_t;

endpackage

>>> rtl/core/first_fit_extent_allocator.sv
// First-fit extent allocator.
// The input channel (in_valid_i / in_stall_o) carries one request per beat:
// mode_i selects allocate or free, req_size_i the length and req_addr_i the
// base of a freed region. The output channel (out_valid_o / out_stall_i)
// returns exactly one result beat per request: grant_addr_o, granted_o and
// table_full_o.
// The free-extent table lives in a single RAM with a registered read port,
// and one shared 33-bit adder does the sums and magnitude compares on
// addresses and lengths. An allocate reads entries in order until one is long
// enough, then trims it, or drops it and closes up the entries above when it
// empties; it reports no grant when none fits. A free scans for the first
// entry above its base, then merges with the neighbour below, above or both,
// or inserts a new entry and moves the ones above it up; with every entry
// live, the insert is refused and table_full_o is set. A free of zero, or an
// allocate on an empty table, goes straight to the result. in_stall_o is high
// until the result is registered, so no new request is taken before then.
// A finished result waits in the output register while out_stall_i is high;
// the next request is accepted meanwhile, but its result waits until the
// previous beat is taken.
// Reset empties the table (live count zero) at once; free requests seed it.

`include "first_fit_extent_allocator_defines.svh"

module first_fit_extent_allocator #(
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] req_size_i,
  input  logic [31:0] req_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] grant_addr_o,
  output logic        granted_o,
  output logic        table_full_o
);

  localparam int unsigned W     = ffea_pkg::WORD_W;
  localparam int unsigned IDX_W = $clog2(MAP_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned ENT_W = $bits(ffea_pkg::extent_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CMP,
    S_A_BASE,
    S_F_RD,
    S_F_CMP,
    S_D_BEND,
    S_D_BTOT,
    S_D_AEND,
    S_D_ACT,
    S_SD_RD,
    S_SD_WR,
    S_SU_RD,
    S_SU_WR,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   k_q;
  logic [CNT_W-1:0]   j_q;
  logic               mode_q;
  ffea_pkg::word_t    size_q;
  ffea_pkg::word_t    addr_q;
  ffea_pkg::word_t    prev_base_q;
  ffea_pkg::word_t    prev_len_q;
  ffea_pkg::word_t    cur_base_q;
  ffea_pkg::word_t    cur_len_q;
  ffea_pkg::word_t    diff_q;
  ffea_pkg::word_t    tot_q;
  logic               below_adj_q;
  logic               below_ok_q;
  logic               above_adj_q;
  ffea_pkg::word_t    res_grant_q;
  logic               res_granted_q;
  logic               res_full_q;
  logic               out_valid_q;
  ffea_pkg::word_t    out_grant_q;
  logic               out_granted_q;
  logic               out_full_q;

  logic               in_accept;
  logic               out_load;
  logic [CNT_W-1:0]   k_inc;
  logic [CNT_W-1:0]   k_dec;
  logic [CNT_W-1:0]   j_dec;
  ffea_pkg::word_t    alu_a;
  ffea_pkg::word_t    alu_b;
  logic               alu_ci;
  logic [W:0]         alu_sum;
  logic               merge3;
  logic               merge_up;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  ffea_pkg::extent_t  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  ffea_pkg::extent_t  rd_ent;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign k_inc      = k_q + CNT_W'(1);
  assign k_dec      = k_q - CNT_W'(1);
  assign j_dec      = j_q - CNT_W'(1);
  assign rd_ent     = ffea_pkg::extent_t'(ram_rdata);

  // Shared adder: operands chosen by the sequencer state. A subtract uses
  // the inverted operand with carry in, so the carry out means a >= b.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_ci = 1'b0;
    unique case (state_q)
      S_A_CMP: begin
        alu_a  = rd_ent.len;
        alu_b  = ~size_q;
        alu_ci = 1'b1;
      end
      S_A_BASE: begin
        alu_a = cur_base_q;
        alu_b = size_q;
      end
      S_F_CMP: begin
        alu_a  = addr_q;
        alu_b  = ~rd_ent.base;
        alu_ci = 1'b1;
      end
      S_D_BEND: begin
        alu_a = prev_base_q;
        alu_b = prev_len_q;
      end
      S_D_BTOT: begin
        alu_a = prev_len_q;
        alu_b = size_q;
      end
      S_D_AEND: begin
        alu_a = addr_q;
        alu_b = size_q;
      end
      S_D_ACT: begin
        alu_a = below_ok_q ? tot_q : cur_len_q;
        alu_b = below_ok_q ? cur_len_q : size_q;
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_ci = 1'b0;
      end
    endcase
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b} + {{W{1'b0}}, alu_ci};
  assign merge3   = below_ok_q && above_adj_q && !alu_sum[W];
  assign merge_up = !below_ok_q && above_adj_q && !alu_sum[W];

  // Table RAM read and write control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q[IDX_W-1:0];
    ram_wdata = rd_ent;
    ram_raddr = k_q[IDX_W-1:0];
    unique case (state_q)
      S_A_RD, S_F_RD: begin
        ram_raddr = k_q[IDX_W-1:0];
      end
      S_A_BASE: begin
        ram_we    = 1'b1;
        ram_wdata = '{base: alu_sum[W-1:0], len: diff_q};
      end
      S_D_ACT: begin
        if (below_ok_q) begin
          ram_we    = 1'b1;
          ram_waddr = k_dec[IDX_W-1:0];
          ram_wdata = '{base: prev_base_q, len: (merge3 ? alu_sum[W-1:0] : tot_q)};
        end else if (merge_up) begin
          ram_we    = 1'b1;
          ram_wdata = '{base: addr_q, len: alu_sum[W-1:0]};
        end
      end
      S_SD_RD: begin
        ram_raddr = k_inc[IDX_W-1:0];
      end
      S_SD_WR: begin
        ram_we = 1'b1;
      end
      S_SU_RD: begin
        ram_raddr = j_dec[IDX_W-1:0];
        if (j_q == k_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{base: addr_q, len: size_q};
        end
      end
      S_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffea_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAP_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer with its working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      n_q           <= '0;
      k_q           <= '0;
      j_q           <= '0;
      mode_q        <= ffea_pkg::MODE_ALLOC;
      size_q        <= '0;
      addr_q        <= '0;
      prev_base_q   <= '0;
      prev_len_q    <= '0;
      cur_base_q    <= '0;
      cur_len_q     <= '0;
      diff_q        <= '0;
      tot_q         <= '0;
      below_adj_q   <= 1'b0;
      below_ok_q    <= 1'b0;
      above_adj_q   <= 1'b0;
      res_grant_q   <= '0;
      res_granted_q <= 1'b0;
      res_full_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_grant_q   <= '0;
      out_granted_q <= 1'b0;
      out_full_q    <= 1'b0;
    end else begin
      // The result beat is loaded by the sequencer and leaves when taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mode_q        <= mode_i;
            size_q        <= req_size_i;
            addr_q        <= req_addr_i;
            k_q           <= '0;
            res_grant_q   <= '0;
            res_granted_q <= 1'b0;
            res_full_q    <= 1'b0;
            if (mode_i == ffea_pkg::MODE_ALLOC) begin
              state_q <= (n_q == '0) ? S_RESP : S_A_RD;
            end else begin
              state_q <= (req_size_i == '0) ? S_RESP : S_F_RD;
            end
          end
        end
        S_A_RD: begin
          state_q <= S_A_CMP;
        end
        S_A_CMP: begin
          if (alu_sum[W]) begin
            res_grant_q   <= rd_ent.base;
            res_granted_q <= 1'b1;
            cur_base_q    <= rd_ent.base;
            diff_q        <= alu_sum[W-1:0];
            state_q       <= (alu_sum[W-1:0] == '0) ? S_SD_RD : S_A_BASE;
          end else if (k_inc == n_q) begin
            state_q <= S_RESP;
          end else begin
            k_q     <= k_inc;
            state_q <= S_A_RD;
          end
        end
        S_A_BASE: begin
          state_q <= S_RESP;
        end
        S_F_RD: begin
          state_q <= (k_q == n_q) ? S_D_BEND : S_F_CMP;
        end
        S_F_CMP: begin
          if (alu_sum[W]) begin
            prev_base_q <= rd_ent.base;
            prev_len_q  <= rd_ent.len;
            k_q         <= k_inc;
            state_q     <= S_F_RD;
          end else begin
            cur_base_q <= rd_ent.base;
            cur_len_q  <= rd_ent.len;
            state_q    <= S_D_BEND;
          end
        end
        S_D_BEND: begin
          below_adj_q <= (k_q != '0) && (alu_sum == {1'b0, addr_q});
          state_q     <= S_D_BTOT;
        end
        S_D_BTOT: begin
          below_ok_q <= below_adj_q && !alu_sum[W];
          tot_q      <= alu_sum[W-1:0];
          state_q    <= S_D_AEND;
        end
        S_D_AEND: begin
          above_adj_q <= (k_q != n_q) && (alu_sum == {1'b0, cur_base_q});
          state_q     <= S_D_ACT;
        end
        S_D_ACT: begin
          priority if (below_ok_q) begin
            state_q <= merge3 ? S_SD_RD : S_RESP;
          end else if (merge_up) begin
            state_q <= S_RESP;
          end else if (n_q != CNT_W'(MAP_ENTRIES)) begin
            j_q     <= n_q;
            state_q <= S_SU_RD;
          end else begin
            res_full_q <= 1'b1;
            state_q    <= S_RESP;
          end
        end
        S_SD_RD: begin
          // Entry k is dropped; later entries move down one by one.
          if (k_inc == n_q) begin
            n_q     <= n_q - CNT_W'(1);
            state_q <= S_RESP;
          end else begin
            state_q <= S_SD_WR;
          end
        end
        S_SD_WR: begin
          k_q     <= k_inc;
          state_q <= S_SD_RD;
        end
        S_SU_RD: begin
          // Entries from k up move up one, top first; then k takes the new one.
          if (j_q == k_q) begin
            n_q     <= n_q + CNT_W'(1);
            state_q <= S_RESP;
          end else begin
            state_q <= S_SU_WR;
          end
        end
        S_SU_WR: begin
          j_q     <= j_dec;
          state_q <= S_SU_RD;
        end
        S_RESP: begin
          if (out_load) begin
            out_grant_q   <= res_grant_q;
            out_granted_q <= res_granted_q;
            out_full_q    <= res_full_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grant_addr_o = out_grant_q;
  assign granted_o    = out_granted_q;
  assign table_full_o = out_full_q;

  // The live count never passes the table depth.
  `FFEA_ASSERT(a_count_bound, clk_i, rst_ni, n_q <= CNT_W'(MAP_ENTRIES), "live count overflow")

  // Writes never land above the live region plus one slot.
  `FFEA_ASSERT_IMPL(a_write_range, clk_i, rst_ni, ram_we, CNT_W'(ram_waddr) <= n_q,
                    "write beyond live entries")

  // A result never reports a grant and a full table together.
  `FFEA_ASSERT_IMPL(a_result_excl, clk_i, rst_ni, out_valid_o, !(granted_o && table_full_o),
                    "grant and full together")

  // A refused insert only happens with every entry live.
  `FFEA_ASSERT_IMPL(a_full_count, clk_i, rst_ni, (state_q == S_RESP) && res_full_q,
                    n_q == CNT_W'(MAP_ENTRIES), "full flag with free slots")

  // Only an allocate request can report a grant.
  `FFEA_ASSERT_IMPL(a_grant_alloc, clk_i, rst_ni, (state_q == S_RESP) && res_granted_q,
                    mode_q == ffea_pkg::MODE_ALLOC, "grant on a free request")

endmodule

>>> rtl/core/ffea_ram.sv
module ffea_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb_first_fit_extent_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_extent_allocator;

  typedef ffea_pkg::word_t word_t;

  localparam logic MODE_ALLOC = ffea_pkg::MODE_ALLOC;
  localparam logic MODE_FREE  = ffea_pkg::MODE_FREE;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_PER_PHASE = 542;
  localparam int unsigned CYCLE_LIMIT = 900000;
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PLAN_ROWS = 25;

  // A directed row either carries its own expected beat or takes the predicted one.
  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    word_t grant;
    logic  granted;
    logic  full;
  } grant_t;

  typedef struct packed {
    logic  mode;
    word_t size;
    word_t addr;
  } request_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    grant_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_ALLOC;
  logic [31:0] req_size_i = '0;
  logic [31:0] req_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] grant_addr_o;
  logic        granted_o;
  logic        table_full_o;

  // Shadow copy of the free-extent table, kept in step with accepted requests.
  word_t free_base [TABLE_DEPTH];
  word_t free_len [TABLE_DEPTH];

  grant_t      pending_grants [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;

  first_fit_extent_allocator #(
    .MAP_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .req_size_i  (req_size_i),
    .req_addr_i  (req_addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grant_addr_o(grant_addr_o),
    .granted_o   (granted_o),
    .table_full_o(table_full_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Live extents are the ones ahead of the first zero length.
  function automatic int live_extents();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && free_len[n] != '0) n++;
    return n;
  endfunction

  // Drop entry idx out of n live ones; the entries above it close up.
  function automatic void close_up(int idx, int n);
    for (int k = idx; k + 1 < n; k++) begin
      free_base[k] = free_base[k + 1];
      free_len[k] = free_len[k + 1];
    end
    free_base[n - 1] = '0;
    free_len[n - 1] = '0;
  endfunction

  // Apply one request to the shadow table and return the beat it should produce.
  function automatic grant_t apply_request(request_t req);
    grant_t      r;
    int          n;
    int          i;
    logic [32:0] end_a;
    logic [32:0] below_sum;
    logic [33:0] span;
    logic        below_ok;
    logic        above_adj;
    r = '0;
    n = live_extents();
    i = 0;
    below_ok = 1'b0;
    above_adj = 1'b0;
    below_sum = '0;
    if (req.mode == MODE_ALLOC) begin
      // First fit: the lowest extent that is long enough.
      while (i < n && free_len[i] < req.size) i++;
      if (i < n) begin
        r.grant = free_base[i];
        r.granted = 1'b1;
        free_base[i] = free_base[i] + req.size;
        free_len[i] = free_len[i] - req.size;
        if (free_len[i] == '0) close_up(i, n);
      end
    end else if (req.size != '0) begin
      // Find the first extent above the freed base; ends compare at 33 bits.
      end_a = {1'b0, req.addr} + req.size;
      while (i < n && free_base[i] <= req.addr) i++;
      if (i > 0) begin
        below_sum = {1'b0, free_len[i - 1]} + req.size;
        below_ok = ({1'b0, free_base[i - 1]} + free_len[i - 1] == {1'b0, req.addr}) &&
                   !below_sum[32];
      end
      if (i < n) above_adj = (end_a == {1'b0, free_base[i]});
      if (below_ok) begin
        span = {1'b0, below_sum} + free_len[i];
        if (above_adj && span[33:32] == 2'b00) begin
          free_len[i - 1] = span[31:0];
          close_up(i, n);
        end else begin
          free_len[i - 1] = below_sum[31:0];
        end
      end else if (above_adj && ({1'b0, free_len[i]} + req.size) <= 33'h0_FFFF_FFFF) begin
        free_base[i] = req.addr;
        free_len[i] = free_len[i] + req.size;
      end else if (n < TABLE_DEPTH) begin
        for (int k = n; k > i; k--) begin
          free_base[k] = free_base[k - 1];
          free_len[k] = free_len[k - 1];
        end
        free_base[i] = req.addr;
        free_len[i] = req.size;
      end else begin
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly short lengths, with some full-range and some near the top.
  function automatic word_t random_len();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 70) return $urandom_range(256, 1);
    if (pick < 85) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(512, 0);
  endfunction

  // Build a request around the current table: fits, merges, gap fills and noise.
  function automatic request_t next_request();
    request_t    req;
    int          n;
    int          j;
    int unsigned pick;
    word_t       top;
    n = live_extents();
    pick = $urandom_range(99, 0);
    req.mode = MODE_FREE;
    req.size = random_len();
    req.addr = $urandom();
    if (pick < 40) begin
      req.mode = MODE_ALLOC;
      if (n > 0 && pick < 30) begin
        j = $urandom_range(n - 1, 0);
        case ($urandom_range(3, 0))
          0: req.size = free_len[j];
          1: req.size = free_len[j] - 1;
          2: req.size = free_len[j] + 1;
          default: req.size = free_len[j] >> $urandom_range(31, 1);
        endcase
      end else if (pick < 34) begin
        req.size = '0;
      end
    end else if (pick < 85 && n > 0) begin
      j = $urandom_range(n - 1, 0);
      top = free_base[j] + free_len[j];
      case ($urandom_range(3, 0))
        0: req.addr = top;
        1: begin
          // Fill the gap exactly so both neighbors are touched.
          req.addr = top;
          if (j + 1 < n) req.size = free_base[j + 1] - top;
        end
        2: req.addr = free_base[j] - req.size;
        default: req.addr = top + $urandom_range(64, 1);
      endcase
    end else if (pick < 90) begin
      req.size = '0;
    end
    return req;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // Present one request beat, with random idle cycles ahead of it.
  task automatic send_request(request_t req, logic typed, grant_t want);
    grant_t predicted;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= req.mode;
    req_size_i <= req.size;
    req_addr_i <= req.addr;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(req);
    pending_grants.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Hold the input side idle until every expected beat has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_grants.size() != 0);
  endtask

  // Random stall on the result side.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < dst_stall_pct);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        note_failure($sformatf("unexpected beat: grant_addr %h granted %b table_full %b",
                               grant_addr_o, granted_o, table_full_o));
      end else begin
        want = pending_grants.pop_front();
        if (grant_addr_o !== want.grant || granted_o !== want.granted ||
            table_full_o !== want.full) begin
          note_failure($sformatf(
            "grant_addr %h/%h granted %b/%b table_full %b/%b (expected/actual)",
            want.grant, grant_addr_o, want.granted, granted_o, want.full, table_full_o));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    // Directed requests: empty table, merges, inserts, fits, wrap and overflow corners.
    plan = '{
      '{'{MODE_ALLOC, 32'h0000_0000, 32'h0000_0000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0000, 32'hFFFF_FFFF}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0100, 32'h0000_1000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_0000, 32'h0000_0000}, TYPED, '{32'h1000, 1'b1, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0010, 32'h0000_1100}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0100, 32'h0000_0F00}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0100, 32'h0000_2000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0EF0, 32'h0000_1110}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_0200, 32'h0000_0000}, TYPED, '{32'h0F00, 1'b1, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_2000, 32'h0000_0000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_1000, 32'h0000_0000}, TYPED, '{32'h1100, 1'b1, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0100, 32'hFFFF_FF00}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0010, 32'h0000_0000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'hFFFF_FFEF, 32'h0000_0010}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0001, 32'hFFFF_FFFF}, PREDICTED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000}, TYPED, '{32'h0, 1'b1, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_0100, 32'h0000_0000}, TYPED, '{32'hFFFF_FF00, 1'b1, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_0001, 32'h0000_0000}, TYPED, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{'{MODE_FREE,  32'h7FFF_FF00, 32'h8000_0100}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h8000_0000, 32'h0000_0000}, TYPED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_FREE,  32'h0000_0100, 32'h8000_0000}, PREDICTED, '{32'h0, 1'b0, 1'b0}},
      '{'{MODE_ALLOC, 32'h8000_0000, 32'h0000_0000}, TYPED, '{32'h0, 1'b1, 1'b0}},
      '{'{MODE_ALLOC, 32'h7FFF_FF00, 32'h0000_0000}, TYPED, '{32'h8000_0100, 1'b1, 1'b0}},
      '{'{MODE_ALLOC, 32'h0000_0000, 32'h0000_0000}, TYPED, '{32'h8000_0000, 1'b1, 1'b0}}
    };
    foreach (free_base[k]) begin
      free_base[k] = '0;
      free_len[k] = '0;
    end

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 9;
    dst_stall_pct = 52;
    @(negedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      send_request(plan[r].req, plan[r].typed, plan[r].want);
    end

    // Random phases: light sender gaps first, then heavy ones, then none at all.
    for (int phase = 0; phase < 3; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          src_idle_pct = 9;
          dst_stall_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          dst_stall_pct = 9;
        end
        default: begin
          src_idle_pct = 0;
          dst_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_request(next_request(), PREDICTED, '0);
      end
    end

    // Drain, then give the block time to show any stray beat.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
